// ----- rtl/icos_pkg.sv -----
package icos_pkg;

  // pipeline map
  localparam int ST_IN     = 0;
  localparam int ST_SQ     = 1;
  localparam int ST_NRM    = 2;
  localparam int ST_DIV0   = 3;
  localparam int DIV_SHIFT = 30;
  localparam int ST_SQRT0  = ST_DIV0 + 1 + DIV_SHIFT;
  localparam int SQRT_STEP = 16;
  localparam int ST_FIN    = ST_SQRT0 + SQRT_STEP;
  localparam int NUM_ST    = ST_FIN + 1;

  localparam int ACC_W  = 36;
  localparam int Q_W    = 31;
  localparam int NRM_W  = 35;
  localparam int COORD_W = 16;

  localparam logic [15:0] ONE_Q14    = 16'd16384;
  localparam logic [1:0]  CHILD_LAST = 2'd3;
  localparam logic [1:0]  CHILD_C0   = 2'd0;
  localparam logic [1:0]  CHILD_C1   = 2'd1;
  localparam logic [1:0]  CHILD_CTR  = 2'd2;

  typedef struct packed {
    logic [8:0][COORD_W-1:0] corner;
    logic [2:0][NRM_W-1:0]   nrm;
    logic [8:0]              neg;
    logic [2:0]              zero;
    logic [8:0][ACC_W-1:0]   acc;   // |s|, s^2, remainder, sqrt radicand, result
    logic [8:0][Q_W-1:0]     qr;    // quotient, then root
  } pipe_t;

endpackage

// ----- rtl/icosphere_triangle_subdivide.sv -----
// Icosphere subdivision step: one triangle beat in, four child-triangle beats out
// (corner v0, corner v1, center, corner v2; out_last_child on the fourth). Edge
// midpoints are projected onto the unit sphere with exact rounding and clamped to
// +/-1.0 in Q2.14; a zero-length midpoint comes out as (0,0,0). The datapath is a
// 51-stage pipeline (input, square and norm stages, 31 restoring-division stages,
// 16 square-root stages and a final rounding stage). The input stalls while the last
// stage still owes child beats, since each triangle needs four beats on the result port.
module icosphere_triangle_subdivide import icos_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_v0_x,
  input  logic signed [15:0] in_v0_y,
  input  logic signed [15:0] in_v0_z,
  input  logic signed [15:0] in_v1_x,
  input  logic signed [15:0] in_v1_y,
  input  logic signed [15:0] in_v1_z,
  input  logic signed [15:0] in_v2_x,
  input  logic signed [15:0] in_v2_y,
  input  logic signed [15:0] in_v2_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_v0_x,
  output logic signed [15:0] out_v0_y,
  output logic signed [15:0] out_v0_z,
  output logic signed [15:0] out_v1_x,
  output logic signed [15:0] out_v1_y,
  output logic signed [15:0] out_v1_z,
  output logic signed [15:0] out_v2_x,
  output logic signed [15:0] out_v2_y,
  output logic signed [15:0] out_v2_z,
  output logic [1:0]         out_child_index,
  output logic               out_last_child
);

  pipe_t            p_r   [NUM_ST];
  pipe_t            p_nxt [NUM_ST];
  logic [NUM_ST-1:0] valid_r;
  logic [1:0]        child_r;
  logic              adv;

  assign adv      = !valid_r[ST_FIN] || (!out_stall && child_r == CHILD_LAST);
  assign in_stall = !adv;

  // input stage: midpoint sums, sign and magnitude
  always_comb begin
    logic [8:0][COORD_W-1:0] c;
    logic signed [16:0] s;
    p_nxt[ST_IN] = p_r[ST_IN];
    c = {in_v2_z, in_v2_y, in_v2_x, in_v1_z, in_v1_y, in_v1_x, in_v0_z, in_v0_y, in_v0_x};
    p_nxt[ST_IN].corner = c;
    for (int m = 0; m < 3; m++) begin
      for (int j = 0; j < 3; j++) begin
        // m01, m12, m02
        if (m == 0)      s = 17'(signed'(c[j]))     + 17'(signed'(c[3 + j]));
        else if (m == 1) s = 17'(signed'(c[3 + j])) + 17'(signed'(c[6 + j]));
        else             s = 17'(signed'(c[j]))     + 17'(signed'(c[6 + j]));
        p_nxt[ST_IN].neg[3*m + j] = s[16];
        p_nxt[ST_IN].acc[3*m + j] = ACC_W'(s[16] ? 17'(-s) : 17'(s));
      end
    end
  end

  for (genvar k = 1; k < NUM_ST; k++) begin : g_st
    always_comb begin
      logic [ACC_W-1:0] t;
      logic [Q_W:0]     x;
      logic [Q_W:0]     res;
      logic [Q_W:0]     trial;
      logic [Q_W:0]     bitv;
      logic [15:0]      r;
      p_nxt[k] = p_r[k-1];
      t = '0; x = '0; res = '0; trial = '0; bitv = '0; r = '0;
      if (k == ST_SQ) begin
        for (int l = 0; l < 9; l++)
          p_nxt[k].acc[l] = ACC_W'(p_r[k-1].acc[l][16:0])
                          * ACC_W'(p_r[k-1].acc[l][16:0]);
      end else if (k == ST_NRM) begin
        for (int m = 0; m < 3; m++) begin
          p_nxt[k].nrm[m] = NRM_W'(p_r[k-1].acc[3*m]) + NRM_W'(p_r[k-1].acc[3*m+1])
                          + NRM_W'(p_r[k-1].acc[3*m+2]);
          p_nxt[k].zero[m] = (NRM_W'(p_r[k-1].acc[3*m]) + NRM_W'(p_r[k-1].acc[3*m+1])
                          + NRM_W'(p_r[k-1].acc[3*m+2])) == '0;
        end
      end else if (k == ST_DIV0) begin
        // s^2 <= N, so the top quotient bit needs no shift
        for (int l = 0; l < 9; l++) begin
          if (p_r[k-1].acc[l] >= ACC_W'(p_r[k-1].nrm[l/3])) begin
            p_nxt[k].acc[l] = p_r[k-1].acc[l] - ACC_W'(p_r[k-1].nrm[l/3]);
            p_nxt[k].qr[l]  = Q_W'(1);
          end else begin
            p_nxt[k].qr[l]  = '0;
          end
        end
      end else if (k < ST_SQRT0) begin
        for (int l = 0; l < 9; l++) begin
          t = p_r[k-1].acc[l] << 1;
          if (t >= ACC_W'(p_r[k-1].nrm[l/3])) begin
            p_nxt[k].acc[l] = t - ACC_W'(p_r[k-1].nrm[l/3]);
            p_nxt[k].qr[l]  = {p_r[k-1].qr[l][Q_W-2:0], 1'b1};
          end else begin
            p_nxt[k].acc[l] = t;
            p_nxt[k].qr[l]  = {p_r[k-1].qr[l][Q_W-2:0], 1'b0};
          end
        end
      end else if (k < ST_FIN) begin
        bitv = (Q_W+1)'(1) << (2 * (ST_FIN - 1 - k));
        for (int l = 0; l < 9; l++) begin
          if (k == ST_SQRT0) begin
            x   = {1'b0, p_r[k-1].qr[l]};
            res = '0;
          end else begin
            x   = p_r[k-1].acc[l][Q_W:0];
            res = {1'b0, p_r[k-1].qr[l]};
          end
          trial = res + bitv;
          if (x >= trial) begin
            p_nxt[k].acc[l] = ACC_W'(x - trial);
            p_nxt[k].qr[l]  = Q_W'((res >> 1) + bitv);
          end else begin
            p_nxt[k].acc[l] = ACC_W'(x);
            p_nxt[k].qr[l]  = Q_W'(res >> 1);
          end
        end
      end else begin
        for (int l = 0; l < 9; l++) begin
          r = 16'((p_r[k-1].qr[l][16:0] + 17'd1) >> 1);
          if (r > ONE_Q14) r = ONE_Q14;
          if (p_r[k-1].zero[l/3]) r = '0;
          else if (p_r[k-1].neg[l]) r = 16'(-r);
          p_nxt[k].acc[l] = ACC_W'(r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      child_r <= '0;
    end else begin
      if (adv) valid_r <= {valid_r[NUM_ST-2:0], in_valid};
      if (valid_r[ST_FIN] && !out_stall) child_r <= child_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_ST; k++) p_r[k] <= p_nxt[k];
    end
  end

  logic [2:0][15:0] cv0, cv1, cv2, m01, m12, m02;
  logic [2:0][15:0] ov0, ov1, ov2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cv0[j] = p_r[ST_FIN].corner[j];
      cv1[j] = p_r[ST_FIN].corner[3 + j];
      cv2[j] = p_r[ST_FIN].corner[6 + j];
      m01[j] = p_r[ST_FIN].acc[j][15:0];
      m12[j] = p_r[ST_FIN].acc[3 + j][15:0];
      m02[j] = p_r[ST_FIN].acc[6 + j][15:0];
    end
    case (child_r)
      CHILD_C0:  begin ov0 = cv0; ov1 = m01; ov2 = m02; end
      CHILD_C1:  begin ov0 = m01; ov1 = cv1; ov2 = m12; end
      CHILD_CTR: begin ov0 = m01; ov1 = m12; ov2 = m02; end
      default:   begin ov0 = m02; ov1 = m12; ov2 = cv2; end
    endcase
  end

  assign out_valid       = valid_r[ST_FIN];
  assign out_child_index = child_r;
  assign out_last_child  = (child_r == CHILD_LAST);
  assign out_v0_x = ov0[0];
  assign out_v0_y = ov0[1];
  assign out_v0_z = ov0[2];
  assign out_v1_x = ov1[0];
  assign out_v1_y = ov1[1];
  assign out_v1_z = ov1[2];
  assign out_v2_x = ov2[0];
  assign out_v2_y = ov2[1];
  assign out_v2_z = ov2[2];

endmodule

// ----- rtl/icos_checker.sv -----
module icos_checker import icos_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_v0_x,
  input logic [15:0] out_v2_z,
  input logic [1:0]  out_child_index,
  input logic        out_last_child
);

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_child == (out_child_index == CHILD_LAST)))
    else $error("last flag off the fourth child");

  a_child_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_child_index != CHILD_LAST) |=>
      (out_valid && out_child_index == $past(out_child_index) + 2'd1))
    else $error("child beats not consecutive");

  a_first_child: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> (out_child_index == CHILD_C0))
    else $error("run does not start with child 0");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_child_index) && $stable(out_v0_x) && $stable(out_v2_z)))
    else $error("stalled beat changed");

endmodule

bind icosphere_triangle_subdivide icos_checker u_icos_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_v0_x(out_v0_x), .out_v2_z(out_v2_z),
  .out_child_index(out_child_index), .out_last_child(out_last_child)
);
